[hdl/fsk_nco_alaw_modulator_defines.svh]
// Assertion macros for the FSK NCO A-law modulator.
`ifndef FSK_NCO_ALAW_MODULATOR_DEFINES_SVH
`define FSK_NCO_ALAW_MODULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fsk_pkg.sv]
// Shared types, constants and sine table function for the FSK modulator.
`timescale 1ns / 1ps
`default_nettype none

package fsk_pkg;

    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int CODE_W   = 8;

    // register decode on paddr[2]
    localparam logic REG_STEP_ONE  = 1'b0;
    localparam logic REG_STEP_ZERO = 1'b1;

    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam longint unsigned SINE_PEAK    = 64'd20316;
    localparam int              TAYLOR_TERMS = 7;
    // (2k)(2k+1) for k = 1..7
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    localparam logic [CODE_W-1:0] MASK_POS = 8'hD5;
    localparam logic [CODE_W-1:0] MASK_NEG = 8'h55;

    // stage 1 status handed from the NCO to the output stage
    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

    // Quarter-wave magnitude at offset m of a quarter of 2^qbits entries.
    // Taylor series to x^15 in Q30, evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                      input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          sum;
        x    = (longint'(m) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < TAYLOR_TERMS; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        scaled = (longint'(sum) * SINE_PEAK + (64'd1 << 29)) >> 30;
        if (scaled > SINE_PEAK)
            scaled = SINE_PEAK;
        return scaled[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/fsk_nco.sv]
// Phase accumulator and input stage of the FSK modulator.
`timescale 1ns / 1ps
`default_nettype none

module fsk_nco (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [fsk_pkg::PHASE_W-1:0] step_one,
    input  wire logic [fsk_pkg::PHASE_W-1:0] step_zero,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic                        tx_bit,
    input  wire logic                        block_end,
    input  wire logic                        advance,
    output      fsk_pkg::stage_t             stage,
    output      logic [fsk_pkg::PHASE_W-1:0] phase
);

    logic [fsk_pkg::PHASE_W-1:0] phase_acc_reg;
    logic [fsk_pkg::PHASE_W-1:0] phase_acc_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        last_reg;
    logic                        accept;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        if (accept)
            phase_acc_next = phase_acc_reg + (tx_bit ? step_one : step_zero);
        valid_next = accept || (valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= block_end;
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign phase       = phase_acc_reg;

endmodule

`default_nettype wire

[hdl/fsk_sine_lut.sv]
// Sine lookup from a quarter-wave table with quadrant mirroring.
`timescale 1ns / 1ps
`default_nettype none

module fsk_sine_lut #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic [SINE_ADDR_BITS-1:0]         addr,
    output      logic signed [fsk_pkg::SAMPLE_W-1:0] sample
);

    localparam int QBITS = SINE_ADDR_BITS - 2;
    localparam int QSIZE = 1 << QBITS;

    logic [fsk_pkg::MAG_W-1:0] rom [QSIZE+1];

    for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
        assign rom[g] = fsk_pkg::quarter_sine(g, QBITS);
    end

    logic [1:0]         quad;
    logic [QBITS-1:0]   r;
    logic [QBITS:0]     m;
    logic [fsk_pkg::MAG_W-1:0] mag;

    always_comb
    begin
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        r    = addr[QBITS-1:0];
        // odd quadrants run the quarter wave backwards
        m    = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, r}) : {1'b0, r};
        mag  = rom[m];
        if (quad[1])
            sample = -$signed({1'b0, mag});
        else
            sample = $signed({1'b0, mag});
    end

endmodule

`default_nettype wire

[hdl/fsk_alaw_enc.sv]
// G.711 A-law encoder with even-bit inversion.
`timescale 1ns / 1ps
`default_nettype none

module fsk_alaw_enc (
    input  wire logic signed [fsk_pkg::SAMPLE_W-1:0] sample,
    output      logic        [fsk_pkg::CODE_W-1:0]   code
);

    logic [11:0]                 mag;
    logic [2:0]                  seg;
    logic [2:0]                  shift;
    logic [3:0]                  mant;
    logic [fsk_pkg::CODE_W-1:0]  mask;
    logic [fsk_pkg::SAMPLE_W-1:0] folded;

    always_comb
    begin
        // negative samples use the one's complement magnitude
        folded = sample[fsk_pkg::SAMPLE_W-1] ? ~sample : sample;
        mask   = sample[fsk_pkg::SAMPLE_W-1] ? fsk_pkg::MASK_NEG : fsk_pkg::MASK_POS;
        mag    = folded[14:3];
        // segment = highest set bit at or above bit 5, less 4
        seg = 3'd0;
        for (int i = 5; i < 12; i++) begin
            if (mag[i])
                seg = 3'(i - 4);
        end
        shift = (seg == 3'd0) ? 3'd1 : seg;
        mant  = 4'(mag >> shift);
        code  = {1'b0, seg, mant} ^ mask;
    end

endmodule

`default_nettype wire

[hdl/fsk_nco_alaw_modulator.sv]
// Top level of the binary FSK modulator with NCO and A-law output.
//
// Usage:
//   Input channel (in_valid/in_ready, tx_bit, block_end): one request per
//   data bit. The bit selects phase_step_one or phase_step_zero, which is
//   added to the 32-bit phase accumulator (wraps modulo 2^32).
//   Output channel (out_valid/out_ready, alaw_sample, sample_last): one
//   A-law byte per request, taken from the sine at the new phase; sample_last
//   repeats block_end.
//   Config: APB-style, phase_step_one at 0x0, phase_step_zero at 0x4,
//   pready tied high, no wait states. Write only while the block is idle.
// Path: input accept loads the phase register, then lookup + encode
//   load the output register.
// Throughput: 1 request per cycle while out_ready is high; the lookup and encode
//   path between the phase register and the output register sets the clock limit.
// Stall: while out_ready is low the output holds, stage 1 holds one more
//   request, then in_ready drops. Nothing is dropped or repeated.
// Reset: phase accumulator, both step registers and all valid flags clear.
`timescale 1ns / 1ps
`default_nettype none
`include "fsk_nco_alaw_modulator_defines.svh"

module fsk_nco_alaw_modulator #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    // bit requests
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        tx_bit,
    input  wire logic        block_end,
    // sample results
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [7:0]  alaw_sample,
    output      logic        sample_last
);

    // ---------------- config registers ----------------
    logic [fsk_pkg::PHASE_W-1:0] step_one_reg;
    logic [fsk_pkg::PHASE_W-1:0] step_zero_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_one_reg  <= '0;
            step_zero_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                fsk_pkg::REG_STEP_ONE:  step_one_reg  <= pwdata;
                fsk_pkg::REG_STEP_ZERO: step_zero_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            fsk_pkg::REG_STEP_ONE:  prdata = step_one_reg;
            fsk_pkg::REG_STEP_ZERO: prdata = step_zero_reg;
            default:                prdata = '0;
        endcase
    end

    // ---------------- stage 1: phase accumulator ----------------
    fsk_pkg::stage_t             s1;
    logic [fsk_pkg::PHASE_W-1:0] phase;
    logic                        out_load;

    fsk_nco u_nco (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_one  (step_one_reg),
        .step_zero (step_zero_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tx_bit    (tx_bit),
        .block_end (block_end),
        .advance   (out_load),
        .stage     (s1),
        .phase     (phase)
    );

    // ---------------- stage 2: sine lookup and A-law ----------------
    logic signed [fsk_pkg::SAMPLE_W-1:0] sine;
    logic        [fsk_pkg::CODE_W-1:0]   code;

    fsk_sine_lut #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_lut (
        .addr   (phase[fsk_pkg::PHASE_W-1 -: SINE_ADDR_BITS]),
        .sample (sine)
    );

    fsk_alaw_enc u_enc (
        .sample (sine),
        .code   (code)
    );

    // output register: refills from a valid stage 1 whenever empty or being taken
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [fsk_pkg::CODE_W-1:0] alaw_sample_reg;
    logic                       sample_last_reg;

    assign out_load = s1.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            alaw_sample_reg <= code;
            sample_last_reg <= s1.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign alaw_sample = alaw_sample_reg;
    assign sample_last = sample_last_reg;

    // ---------------- assertions ----------------
    `FSK_ASSERT_NEXT(a_phase_step, in_valid && in_ready, phase == $past(phase + (tx_bit ? step_one_reg : step_zero_reg)), "phase did not advance by the selected step")
    `FSK_ASSERT_NEXT(a_phase_hold, !(in_valid && in_ready), $stable(phase), "phase moved without an accepted request")
    `FSK_ASSERT_NEXT(a_s1_keep, s1.valid && !out_load, s1.valid, "stage 1 request lost while output stalled")
    `FSK_ASSERT_NOW(a_out_src, $rose(out_valid), $past(s1.valid), "output valid without a stage 1 request")

endmodule

`default_nettype wire
